>>> hdl/svd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svd_pkg
// shared types, register codes, reset values and the sine table generator
// for the stereo vibrato delay unit
// ----------------------------------------------------------------------------
package svd_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_LFO_SHAPE      = 2'd0;
   localparam csr_index_type CSR_LFO_PHASE_STEP = 2'd1;
   localparam csr_index_type CSR_DELAY_SPAN     = 2'd2;

   localparam int PHASE_W    = 32;
   localparam int SPAN_REG_W = 13;

   localparam logic                  RST_LFO_SHAPE  = 1'b0;
   localparam logic [PHASE_W-1:0]    RST_PHASE_STEP = 32'd447392;
   localparam logic [SPAN_REG_W-1:0] RST_DELAY_SPAN = 13'd480;

   // lfo shape select
   localparam logic SHAPE_SINE     = 1'b0;
   localparam logic SHAPE_TRIANGLE = 1'b1;

   // sine table entries are signed q15, full scale 32767
   localparam int SINE_BITS = 16;
   typedef logic signed [SINE_BITS-1:0] sine_type;
   localparam int SINE_AMP  = 32767;
   // divide by 2^15 - 1 is done as a shift series plus a remainder fix
   localparam int DIV_SHIFT = 15;
   localparam int REM_W     = DIV_SHIFT + 2;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
   localparam logic [63:0] Q30_ROUND   = 64'd536870912;

   // q30 taylor series on the reflected quarter wave, rounded to q15
   function automatic sine_type sine_of_phase(input logic [PHASE_W-1:0] p);
      logic [1:0]  quad;
      logic [63:0] f;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      quad = p[31:30];
      f    = {34'd0, p[29:0]};
      if (quad[0]) begin
         f = Q30_ONE - f;
      end
      x  = (f * Q30_HALF_PI) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      v = (s * 64'd32767 + Q30_ROUND) >> 30;
      if (quad[1]) begin
         v = 64'd0 - v;
      end
      return sine_type'(v[SINE_BITS-1:0]);
   endfunction

endpackage
`default_nettype wire

>>> hdl/svd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svd_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module svd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/stereo_vibrato_delay_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_vibrato_delay_unit
// stereo vibrato: lfo modulated delay line with linear interpolation
// ----------------------------------------------------------------------------
// Each request carries one stereo frame and yields one response frame. Both
// channels share one ring memory (left and right side by side in a word) of
// which the first delay_span entries are in use. A 32-bit phase accumulator
// drives a sine (table) or triangle lfo that sets a fractional read offset of
// 0 to span-1 samples with OFFSET_FRAC_BITS fraction bits; the response blends
// the two neighboring stored samples, then the new frame is written at the
// write position. One request is in flight at a time; a sine frame adds the
// divide by 32767 (S_QEST, S_REM, S_FIX) that scales the sine offset, and the
// two ring reads share the single read port (S_RD0, S_RD1). A response that
// is not taken holds the unit in its last step. The ring needs no clearing
// pass after reset: entries are written in order from zero, so a fill count
// tells which entries still read as zero. Configuration must be written only
// while idle; the unit itself does not enforce it.
// ----------------------------------------------------------------------------
module stereo_vibrato_delay_unit #(
   parameter int DEPTH            = 4096,
   parameter int SAMPLE_BITS      = 16,
   parameter int SINE_ENTRIES     = 1024,
   parameter int OFFSET_FRAC_BITS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]      req_left_in,
   input  wire logic signed [SAMPLE_BITS-1:0]      req_right_in,
   input  wire logic                               req_block_last_in,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed      [SAMPLE_BITS-1:0]      rsp_left_out,
   output logic signed      [SAMPLE_BITS-1:0]      rsp_right_out,
   output logic                                    rsp_block_last_out,
   // configuration write port
   input  wire logic                               csr_wr_en,
   input  wire svd_pkg::csr_index_type             csr_index,
   input  wire logic [svd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // widths
   localparam int AW    = $clog2(DEPTH);          // ring address
   localparam int SIW   = $clog2(SINE_ENTRIES);   // sine table index
   localparam int F     = OFFSET_FRAC_BITS;
   localparam int OW    = AW + F;                 // offset, fractional
   localparam int PW    = OW + 1;                 // position sum
   localparam int AMW   = svd_pkg::SINE_BITS + AW; // sine level times span-1
   localparam int NW    = AMW + F - 1;            // dividend over 32767
   localparam int TW    = svd_pkg::PHASE_W + AW;  // triangle product
   localparam int BW    = SAMPLE_BITS + F + 2;    // blend accumulator
   localparam int SCALE = 1 << F;
   localparam int RW    = 2 * SAMPLE_BITS;        // ring word

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LFO   = 4'd1;
   localparam logic [3:0] S_SCALE = 4'd2;
   localparam logic [3:0] S_QEST  = 4'd3;
   localparam logic [3:0] S_REM   = 4'd4;
   localparam logic [3:0] S_FIX   = 4'd5;
   localparam logic [3:0] S_POS   = 4'd6;
   localparam logic [3:0] S_RD0   = 4'd7;
   localparam logic [3:0] S_RD1   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   // sine table, built at elaboration
   typedef svd_pkg::sine_type sine_tab_type [SINE_ENTRIES];

   function automatic sine_tab_type build_sine_table();
      sine_tab_type tab;
      logic [63:0]  ph;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         ph     = (64'(k) << 32) / 64'(SINE_ENTRIES);
         tab[k] = svd_pkg::sine_of_phase(ph[31:0]);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TABLE = build_sine_table();

   // linear blend, rounded half up
   function automatic logic [SAMPLE_BITS-1:0] blend_fn(
      input logic [SAMPLE_BITS-1:0] older,
      input logic [SAMPLE_BITS-1:0] newer,
      input logic [F-1:0]           frac
   );
      logic signed [BW-1:0] w_new;
      logic signed [BW-1:0] w_old;
      logic signed [BW-1:0] acc;
      w_new = $signed(BW'(frac));
      w_old = $signed(BW'(SCALE)) - w_new;
      acc   = BW'($signed(older)) * w_old + BW'($signed(newer)) * w_new
            + $signed(BW'(SCALE / 2));
      return SAMPLE_BITS'(acc >>> F);
   endfunction

   // control registers
   logic [3:0]                          state_ff, state_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]                       wp_ff, wp_in;
   logic [AW:0]                         fill_ff, fill_in;
   logic [svd_pkg::PHASE_W-1:0]         phase_ff, phase_in;
   logic                                shape_ff;
   logic [svd_pkg::PHASE_W-1:0]         step_ff;
   logic [svd_pkg::SPAN_REG_W-1:0]      span_ff;

   // per-frame working registers
   logic                                shape_sel_ff;
   logic [AW:0]                         span_eff_ff;
   logic [AW-1:0]                       span_m1_ff;
   logic [AW-1:0]                       wp_eff_ff;
   logic [svd_pkg::PHASE_W-1:0]         tri_d_ff;
   logic [SIW-1:0]                      sine_idx_ff;
   logic [svd_pkg::SINE_BITS-1:0]       sine_val_ff;
   logic [TW-1:0]                       tri_prod_ff;
   logic [AMW-1:0]                      sine_prod_ff;
   logic [OW-1:0]                       q_ff;
   logic [svd_pkg::REM_W-1:0]           rem_ff;
   logic [OW-1:0]                       offset_ff;
   logic [AW-1:0]                       idx_ff;
   logic [AW-1:0]                       nxt_ff;
   logic [F-1:0]                        frac_ff;
   logic                                idx_ok_ff;
   logic                                nxt_ok_ff;
   logic [RW-1:0]                       older_ff;
   logic [SAMPLE_BITS-1:0]              left_ff;
   logic [SAMPLE_BITS-1:0]              right_ff;
   logic                                last_ff;
   logic [SAMPLE_BITS-1:0]              rsp_left_ff;
   logic [SAMPLE_BITS-1:0]              rsp_right_ff;
   logic                                rsp_last_ff;

   // combinational
   logic                                accept;
   logic                                out_free;
   logic                                retire;
   logic [AW:0]                         span_eff;
   logic [AW-1:0]                       wp_eff;
   logic [svd_pkg::PHASE_W-1:0]         tri_d;
   logic [63:0]                         sine_idx_prod;
   logic [svd_pkg::SINE_BITS-1:0]       sine_u;
   logic [NW-1:0]                       n_val;
   logic [NW-1:0]                       q_sum;
   logic [NW-1:0]                       rem_full;
   logic [1:0]                          fix_cnt;
   logic [OW-1:0]                       wp_q;
   logic [PW-1:0]                       pos_sum;
   logic [PW-1:0]                       span_q;
   logic [PW:0]                         pos_diff;
   logic [PW-1:0]                       pos;
   logic [AW:0]                         nxt_sum;
   logic [AW:0]                         wp_sum;
   logic [AW-1:0]                       rd_addr;
   logic [RW-1:0]                       rd_data;
   logic [RW-1:0]                       newer;
   logic [RW-1:0]                       wr_data;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign retire    = (state_ff == S_OUT) && out_free;
   assign req_ready = (state_ff == S_IDLE);

   // span clamp and write position fixup for the frame being accepted
   always_comb begin
      if (span_ff < svd_pkg::SPAN_REG_W'(2)) begin
         span_eff = (AW+1)'(2);
      end else if (32'(span_ff) > 32'(DEPTH)) begin
         span_eff = (AW+1)'(DEPTH);
      end else begin
         span_eff = (AW+1)'(span_ff);
      end
      wp_eff = ({1'b0, wp_ff} >= span_eff) ? '0 : wp_ff;
   end

   // triangle distance from mid phase, sine table index
   assign tri_d = phase_ff[31] ? {1'b0, phase_ff[30:0]}
                               : 32'h8000_0000 - phase_ff;
   assign sine_idx_prod = 64'(phase_ff) * 64'(SINE_ENTRIES);

   // sine level shifted to 0..65534
   assign sine_u = sine_val_ff + svd_pkg::SINE_BITS'(svd_pkg::SINE_AMP);

   // floor(n / 32767): shift series underestimates by at most three
   assign n_val    = NW'(sine_prod_ff) << (F - 1);
   assign q_sum    = (n_val >> svd_pkg::DIV_SHIFT) + (n_val >> (2 * svd_pkg::DIV_SHIFT))
                   + (n_val >> (3 * svd_pkg::DIV_SHIFT));
   assign rem_full = n_val - (NW'(q_ff) << svd_pkg::DIV_SHIFT) + NW'(q_ff);
   assign fix_cnt  = {1'b0, rem_ff >= svd_pkg::REM_W'(svd_pkg::SINE_AMP)}
                   + {1'b0, rem_ff >= svd_pkg::REM_W'(2 * svd_pkg::SINE_AMP)}
                   + {1'b0, rem_ff >= svd_pkg::REM_W'(3 * svd_pkg::SINE_AMP)};

   // read position, wrapped once around the span
   assign wp_q     = {wp_eff_ff, {F{1'b0}}};
   assign pos_sum  = PW'(wp_q) + PW'(offset_ff);
   assign span_q   = {span_eff_ff, {F{1'b0}}};
   assign pos_diff = {1'b0, pos_sum} - {1'b0, span_q};
   assign pos      = pos_diff[PW] ? pos_sum : pos_diff[PW-1:0];

   assign nxt_sum = {1'b0, idx_ff} + (AW+1)'(1);
   assign wp_sum  = {1'b0, wp_eff_ff} + (AW+1)'(1);

   // ring memory, left in the upper half of the word
   assign rd_addr = (state_ff == S_RD0) ? idx_ff : nxt_ff;
   assign wr_data = {left_ff, right_ff};
   assign newer   = nxt_ok_ff ? rd_data : '0;

   svd_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (retire),
      .wr_addr (wp_eff_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LFO;
            end
         end
         S_LFO:   state_in = S_SCALE;
         S_SCALE: state_in = (shape_sel_ff == svd_pkg::SHAPE_TRIANGLE) ? S_POS : S_QEST;
         S_QEST:  state_in = S_REM;
         S_REM:   state_in = S_FIX;
         S_FIX:   state_in = S_POS;
         S_POS:   state_in = S_RD0;
         S_RD0:   state_in = S_RD1;
         S_RD1:   state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // persistent state next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      phase_in     = phase_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         // lfo uses the phase before this frame's step
         phase_in = phase_ff + step_ff;
      end
      if (retire) begin
         rsp_valid_in = 1'b1;
         wp_in        = (wp_sum >= span_eff_ff) ? '0 : wp_sum[AW-1:0];
         // written entries always form a prefix of the ring
         fill_in      = (wp_sum > fill_ff) ? wp_sum : fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         phase_ff     <= '0;
         shape_ff     <= svd_pkg::RST_LFO_SHAPE;
         step_ff      <= svd_pkg::RST_PHASE_STEP;
         span_ff      <= svd_pkg::RST_DELAY_SPAN;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         if (csr_wr_en) begin
            case (csr_index)
               svd_pkg::CSR_LFO_SHAPE:      shape_ff <= csr_wdata[0];
               svd_pkg::CSR_LFO_PHASE_STEP: step_ff  <= csr_wdata;
               svd_pkg::CSR_DELAY_SPAN:     span_ff  <= csr_wdata[svd_pkg::SPAN_REG_W-1:0];
               default: ; // unknown index ignored
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      // capture the frame and its lfo inputs
      if (accept) begin
         shape_sel_ff <= shape_ff;
         span_eff_ff  <= span_eff;
         span_m1_ff   <= AW'(span_eff - (AW+1)'(1));
         wp_eff_ff    <= wp_eff;
         tri_d_ff     <= tri_d;
         sine_idx_ff  <= sine_idx_prod[32 +: SIW];
         left_ff      <= req_left_in;
         right_ff     <= req_right_in;
         last_ff      <= req_block_last_in;
      end
      // table read and triangle scaling
      if (state_ff == S_LFO) begin
         sine_val_ff <= SINE_TABLE[sine_idx_ff];
         tri_prod_ff <= TW'(tri_d_ff) * TW'(span_m1_ff);
      end
      if (state_ff == S_SCALE) begin
         sine_prod_ff <= AMW'(sine_u) * AMW'(span_m1_ff);
         offset_ff    <= tri_prod_ff[31-F +: OW];
      end
      if (state_ff == S_QEST) begin
         q_ff <= OW'(q_sum);
      end
      if (state_ff == S_REM) begin
         rem_ff <= svd_pkg::REM_W'(rem_full);
      end
      if (state_ff == S_FIX) begin
         offset_ff <= q_ff + OW'(fix_cnt);
      end
      if (state_ff == S_POS) begin
         idx_ff  <= pos[F +: AW];
         frac_ff <= pos[F-1:0];
      end
      // first read issued; entries past the fill count read as zero
      if (state_ff == S_RD0) begin
         nxt_ff    <= (nxt_sum >= span_eff_ff) ? '0 : nxt_sum[AW-1:0];
         idx_ok_ff <= ({1'b0, idx_ff} < fill_ff);
      end
      if (state_ff == S_RD1) begin
         older_ff  <= idx_ok_ff ? rd_data : '0;
         nxt_ok_ff <= ({1'b0, nxt_ff} < fill_ff);
      end
      if (retire) begin
         rsp_left_ff  <= blend_fn(older_ff[RW-1 -: SAMPLE_BITS],
                                  newer[RW-1 -: SAMPLE_BITS], frac_ff);
         rsp_right_ff <= blend_fn(older_ff[SAMPLE_BITS-1:0],
                                  newer[SAMPLE_BITS-1:0], frac_ff);
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_out       = rsp_left_ff;
   assign rsp_right_out      = rsp_right_ff;
   assign rsp_block_last_out = rsp_last_ff;

endmodule
`default_nettype wire

>>> hdl/svd_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svd_check
// port level checks for the stereo vibrato delay unit, bound to the top
// ----------------------------------------------------------------------------
module svd_check #(
   parameter int SAMPLE_BITS = 16
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic [SAMPLE_BITS-1:0]        rsp_left_out,
   input wire logic [SAMPLE_BITS-1:0]        rsp_right_out,
   input wire logic                          rsp_block_last_out,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready
);

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left_out) && $stable(rsp_right_out)
                                  && $stable(rsp_block_last_out))
      else $error("response payload changed while stalled");

   // one request at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   // a response never appears right after a request is taken
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response too early after request");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind stereo_vibrato_delay_unit svd_check #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_svd_check (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_left_out       (rsp_left_out),
   .rsp_right_out      (rsp_right_out),
   .rsp_block_last_out (rsp_block_last_out),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready)
);
`default_nettype wire

>>> dv/stereo_vibrato_delay_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_vibrato_delay_unit_test
// self-checking testbench for the stereo vibrato delay unit
// ----------------------------------------------------------------------------
// A directed table of register writes and frames comes first: extremes of the
// samples, both lfo shapes, span clamping, a write position left beyond a
// shrunk span, read wrap and a read of the slot about to be written. Then
// randomized phases run under changing lfo settings and idling patterns.
// Every response is compared with an in-bench delay line model or typed samples.
// ----------------------------------------------------------------------------
module stereo_vibrato_delay_unit_test;

   localparam int RING_DEPTH       = 4096;
   localparam int SAMPLE_W         = 16;
   localparam int SINE_SIZE        = 1024;
   localparam int SINE_IDX_W       = $clog2(SINE_SIZE);
   localparam int FRAC_BITS        = 8;
   // settle time, which covers any ring write still pending
   localparam int SETTLE_CYCLES    = 20;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int RANDOM_PHASES    = 9;
   localparam int FRAMES_PER_PHASE = 60;
   // the only index the register port leaves unused
   localparam svd_pkg::csr_index_type CSR_SPARE_INDEX = 2'd3;

   localparam logic [63:0] Q30_UNIT         = 64'd1073741824;
   localparam logic [63:0] Q30_QUARTER_TURN = 64'd1686629713;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       last;
   } stereo_frame_type;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum logic {ROW_CSR, ROW_FRAME} row_kind_type;

   // one line of the directed table: a register write or a frame
   typedef struct {
      row_kind_type                     kind;
      svd_pkg::csr_index_type           index;
      logic [svd_pkg::CSR_DATA_W-1:0]   data;
      stereo_frame_type                 frame;
      bit                               typed;
      sample_type                       typed_left;
      sample_type                       typed_right;
   } plan_row_type;

   // ports of the unit; the inputs are known from time zero
   logic                             clock              = 1'b0;
   logic                             reset              = 1'b1;
   logic                             req_valid          = 1'b0;
   logic                             req_ready;
   sample_type                       req_left_in        = '0;
   sample_type                       req_right_in       = '0;
   logic                             req_block_last_in  = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready          = 1'b0;
   sample_type                       rsp_left_out;
   sample_type                       rsp_right_out;
   logic                             rsp_block_last_out;
   logic                             csr_wr_en          = 1'b0;
   svd_pkg::csr_index_type           csr_index          = svd_pkg::CSR_LFO_SHAPE;
   logic [svd_pkg::CSR_DATA_W-1:0]   csr_wdata          = '0;

   // typed expectation that travels with the request payload
   logic                             req_typed          = 1'b0;
   sample_type                       req_typed_left     = '0;
   sample_type                       req_typed_right    = '0;

   // delay line model: sine table, both rings, write slot, lfo and registers
   int                               sine_tab [SINE_SIZE];
   sample_type                       left_hist [RING_DEPTH];
   sample_type                       right_hist [RING_DEPTH];
   logic [11:0]                      write_slot;
   logic [svd_pkg::PHASE_W-1:0]      lfo_acc;
   logic                             lfo_tri;
   logic [svd_pkg::PHASE_W-1:0]      lfo_inc;
   logic [svd_pkg::SPAN_REG_W-1:0]   span_setting;

   // frames the unit still owes, oldest first
   stereo_frame_type                 frames_due [$];
   int                               fail_count = 0;

   // pacing of both sides
   idle_mode_type                    idle_mode  = IDLE_NONE;
   int                               hold_req   = 0;
   int                               hold_seen  = 0;
   int                               hold_left  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stereo_vibrato_delay_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_left_in        (req_left_in),
      .req_right_in       (req_right_in),
      .req_block_last_in  (req_block_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_left_out       (rsp_left_out),
      .rsp_right_out      (rsp_right_out),
      .rsp_block_last_out (rsp_block_last_out),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // q30 taylor series to x^9 on the reflected quarter wave, rounded to q15
   function automatic int quarter_wave_sine(input logic [svd_pkg::PHASE_W-1:0] p);
      logic [63:0] f;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      f = {34'd0, p[29:0]};
      if (p[30]) begin
         f = Q30_UNIT - f;
      end
      x  = (f * Q30_QUARTER_TURN) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_UNIT - x2 / 64'd72;
      t  = Q30_UNIT - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_UNIT - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_UNIT - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      if (s > Q30_UNIT) begin
         s = Q30_UNIT;
      end
      v = (s * 64'd32767 + 64'd536870912) >> 30;
      return p[31] ? -int'(v) : int'(v);
   endfunction

   // linear blend of two neighboring taps, rounded half up
   function automatic sample_type mix_taps(input sample_type older, input sample_type newer,
                                           input int frac);
      longint acc;
      acc = longint'(older) * ((1 << FRAC_BITS) - frac) + longint'(newer) * frac;
      acc = (acc + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      return acc[SAMPLE_W-1:0];
   endfunction

   // one frame through the delay line: read and blend, then write, then step lfo
   task automatic advance_vibrato(input stereo_frame_type din, output stereo_frame_type dout);
      logic [63:0] span;
      logic [63:0] wp;
      logic [63:0] tri_gap;
      logic [63:0] offset;
      logic [63:0] span_q;
      logic [63:0] pos;
      logic [63:0] idx;
      logic [63:0] nxt;
      logic [63:0] frac;
      int          level;
      span = span_setting;
      // span clamps to the ring limits
      if (span < 2) begin
         span = 2;
      end
      if (span > RING_DEPTH) begin
         span = RING_DEPTH;
      end
      // write slot left beyond a shrunk span restarts at zero
      wp = write_slot;
      if (wp >= span) begin
         wp = 0;
      end
      if (lfo_tri == svd_pkg::SHAPE_TRIANGLE) begin
         tri_gap = (lfo_acc >= 32'h8000_0000) ? {32'd0, lfo_acc} - 64'h8000_0000
                                              : 64'h8000_0000 - {32'd0, lfo_acc};
         offset = ((tri_gap * (span - 1)) << FRAC_BITS) >> 31;
      end else begin
         level  = sine_tab[lfo_acc[svd_pkg::PHASE_W-1 -: SINE_IDX_W]];
         offset = ((64'(level + svd_pkg::SINE_AMP) * (span - 1)) << FRAC_BITS) / 64'd65534;
      end
      span_q = span << FRAC_BITS;
      pos    = (wp << FRAC_BITS) + offset;
      if (pos >= span_q) begin
         pos = pos - span_q;
      end
      if (pos >= span_q) begin
         pos = 0;
      end
      idx  = pos >> FRAC_BITS;
      frac = pos & ((64'd1 << FRAC_BITS) - 1);
      nxt  = idx + 1;
      if (nxt >= span) begin
         nxt = 0;
      end
      // the current slot is read before it is overwritten
      dout.left  = mix_taps(left_hist[idx], left_hist[nxt], int'(frac));
      dout.right = mix_taps(right_hist[idx], right_hist[nxt], int'(frac));
      dout.last  = din.last;
      left_hist[wp]  = din.left;
      right_hist[wp] = din.right;
      wp = wp + 1;
      if (wp >= span) begin
         wp = 0;
      end
      write_slot = wp[11:0];
      lfo_acc    = lfo_acc + lfo_inc;
   endtask

   function automatic plan_row_type csr_row(input svd_pkg::csr_index_type index,
                                            input logic [svd_pkg::CSR_DATA_W-1:0] data);
      plan_row_type r;
      r.kind        = ROW_CSR;
      r.index       = index;
      r.data        = data;
      r.frame       = '0;
      r.typed       = 1'b0;
      r.typed_left  = '0;
      r.typed_right = '0;
      return r;
   endfunction

   function automatic plan_row_type frame_row(input sample_type left, input sample_type right,
                                              input logic last, input bit typed,
                                              input sample_type typed_left,
                                              input sample_type typed_right);
      plan_row_type r;
      r.kind        = ROW_FRAME;
      r.index       = CSR_SPARE_INDEX;
      r.data        = '0;
      r.frame.left  = left;
      r.frame.right = right;
      r.frame.last  = last;
      r.typed       = typed;
      r.typed_left  = typed_left;
      r.typed_right = typed_right;
      return r;
   endfunction

   // mostly uniform samples, now and then a full-scale or zero-crossing value
   function automatic sample_type pick_sample();
      case ($urandom_range(15))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic bit sender_waits();
      int pct;
      pct = (idle_mode == IDLE_SENDER) ? 53 : (idle_mode == IDLE_BOTH) ? 8 : 0;
      return $urandom_range(99) < pct;
   endfunction

   // register write, one per clock; the caller drops the enable afterwards
   task automatic write_reg(input svd_pkg::csr_index_type index,
                            input logic [svd_pkg::CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         svd_pkg::CSR_LFO_SHAPE:      lfo_tri      = data[0];
         svd_pkg::CSR_LFO_PHASE_STEP: lfo_inc      = data;
         svd_pkg::CSR_DELAY_SPAN:     span_setting = data[svd_pkg::SPAN_REG_W-1:0];
         default: ;
      endcase
   endtask

   // stop offering, let every owed frame come back, then let the unit go quiet
   task automatic settle_unit();
      req_valid <= 1'b0;
      do @(posedge clock); while (frames_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // present one request, with random gaps ahead of it, and hold until taken
   task automatic offer_frame(input stereo_frame_type fr, input bit typed,
                              input sample_type typed_left, input sample_type typed_right);
      while (sender_waits()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_left_in       <= fr.left;
      req_right_in      <= fr.right;
      req_block_last_in <= fr.last;
      req_typed         <= typed;
      req_typed_left    <= typed_left;
      req_typed_right   <= typed_right;
      do @(posedge clock); while (!req_ready);
   endtask

   // each accepted request goes through the model; typed rows override the samples
   always @(posedge clock) begin : request_capture
      stereo_frame_type din;
      stereo_frame_type dout;
      if (!reset && req_valid && req_ready) begin
         din.left  = req_left_in;
         din.right = req_right_in;
         din.last  = req_block_last_in;
         advance_vibrato(din, dout);
         if (req_typed) begin
            dout.left  = req_typed_left;
            dout.right = req_typed_right;
         end
         frames_due.push_back(dout);
      end
   end

   // response side pacing: random stalls, plus one long hold-off on request
   always @(posedge clock) begin : response_pacing
      int pct;
      pct = (idle_mode == IDLE_RECEIVER) ? 53 : (idle_mode == IDLE_BOTH) ? 8 : 0;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= pct);
      end
   end

   // every accepted response against the oldest owed frame
   always @(posedge clock) begin : response_check
      stereo_frame_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_due.size() == 0) begin
            $error("response with no request owed: left_out %0d right_out %0d",
                   rsp_left_out, rsp_right_out);
            fail_count++;
         end else begin
            want = frames_due.pop_front();
            if (rsp_left_out !== want.left) begin
               $error("left_out: expected %0d, got %0d", $signed(want.left), rsp_left_out);
               fail_count++;
            end
            if (rsp_right_out !== want.right) begin
               $error("right_out: expected %0d, got %0d", $signed(want.right), rsp_right_out);
               fail_count++;
            end
            if (rsp_block_last_out !== want.last) begin
               $error("block_last_out: expected %0b, got %0b", want.last, rsp_block_last_out);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      plan_row_type                     plan [$];
      row_kind_type                     prev_kind;
      stereo_frame_type                 fr;
      logic [svd_pkg::CSR_DATA_W-1:0]   step_data;
      logic [svd_pkg::SPAN_REG_W-1:0]   span_val;

      // model at its reset state
      for (int k = 0; k < SINE_SIZE; k++) begin
         sine_tab[k] = quarter_wave_sine(svd_pkg::PHASE_W'(k)
                                         << (svd_pkg::PHASE_W - SINE_IDX_W));
      end
      for (int k = 0; k < RING_DEPTH; k++) begin
         left_hist[k]  = '0;
         right_hist[k] = '0;
      end
      write_slot   = '0;
      lfo_acc      = '0;
      lfo_tri      = svd_pkg::RST_LFO_SHAPE;
      lfo_inc      = svd_pkg::RST_PHASE_STEP;
      span_setting = svd_pkg::RST_DELAY_SPAN;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // frozen triangle at phase zero, span 2: each frame returns the one before
      // it, and the first returns the cleared ring
      plan.push_back(csr_row(svd_pkg::CSR_LFO_SHAPE,      32'd1));
      plan.push_back(csr_row(svd_pkg::CSR_LFO_PHASE_STEP, 32'd0));
      plan.push_back(csr_row(svd_pkg::CSR_DELAY_SPAN,     32'd2));
      plan.push_back(frame_row(16'sh7FFF, 16'sh8000, 1'b1, 1, 16'sh0000, 16'sh0000));
      plan.push_back(frame_row(16'sh8000, 16'sh7FFF, 1'b0, 1, 16'sh7FFF, 16'sh8000));
      plan.push_back(frame_row(16'sh0000, 16'shFFFF, 1'b1, 1, 16'sh8000, 16'sh7FFF));
      plan.push_back(frame_row(16'shFFFF, 16'sh0000, 1'b0, 1, 16'sh0000, 16'shFFFF));
      plan.push_back(frame_row(16'sh0001, 16'sh7FFE, 1'b1, 1, 16'shFFFF, 16'sh0000));
      // sine with stray upper shape bits, spare index ignored, span over the
      // ring clamps to full depth, phase running backwards
      plan.push_back(csr_row(svd_pkg::CSR_LFO_SHAPE,      32'hFFFF_FFFE));
      plan.push_back(csr_row(CSR_SPARE_INDEX,             32'hFFFF_FFFF));
      plan.push_back(csr_row(svd_pkg::CSR_DELAY_SPAN,     32'hFFFF_FFFF));
      plan.push_back(csr_row(svd_pkg::CSR_LFO_PHASE_STEP, 32'hFFFF_FFFF));
      plan.push_back(frame_row(16'sh7FFF, 16'sh7FFF, 1'b1, 0, '0, '0));
      plan.push_back(frame_row(16'sh8000, 16'sh8000, 1'b0, 0, '0, '0));
      plan.push_back(frame_row(16'sh1234, 16'shEDCB, 1'b1, 0, '0, '0));
      plan.push_back(frame_row(16'shFFFF, 16'sh0001, 1'b0, 0, '0, '0));
      plan.push_back(frame_row(16'sh5555, 16'shAAAA, 1'b1, 0, '0, '0));
      // span zero clamps up to 2 with the write slot beyond it; half-turn triangle
      // steps put every other frame on offset zero, a read of the slot being written
      plan.push_back(csr_row(svd_pkg::CSR_DELAY_SPAN,     32'hFFFF_E000));
      plan.push_back(csr_row(svd_pkg::CSR_LFO_SHAPE,      32'd1));
      plan.push_back(csr_row(svd_pkg::CSR_LFO_PHASE_STEP, 32'h8000_0000));
      plan.push_back(frame_row(16'sh4000, 16'shC000, 1'b0, 0, '0, '0));
      plan.push_back(frame_row(16'sh7FFF, 16'sh8000, 1'b1, 0, '0, '0));
      plan.push_back(frame_row(16'sh0000, 16'sh0000, 1'b0, 0, '0, '0));
      plan.push_back(frame_row(16'sh8001, 16'sh7FFE, 1'b1, 0, '0, '0));
      // one past the ring depth, sine again
      plan.push_back(csr_row(svd_pkg::CSR_DELAY_SPAN,     32'd4097));
      plan.push_back(csr_row(svd_pkg::CSR_LFO_SHAPE,      32'd0));
      plan.push_back(csr_row(svd_pkg::CSR_LFO_PHASE_STEP, 32'h0123_4567));
      plan.push_back(frame_row(16'sh2AAA, 16'shD555, 1'b0, 0, '0, '0));
      plan.push_back(frame_row(16'sh8000, 16'sh7FFF, 1'b1, 0, '0, '0));
      plan.push_back(frame_row(16'sh0F0F, 16'shF0F0, 1'b0, 0, '0, '0));

      // register writes only once the unit has gone quiet
      prev_kind = ROW_FRAME;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (prev_kind == ROW_FRAME) begin
               settle_unit();
            end
            write_reg(plan[i].index, plan[i].data);
         end else begin
            if (prev_kind == ROW_CSR) begin
               csr_wr_en <= 1'b0;
            end
            offer_frame(plan[i].frame, plan[i].typed, plan[i].typed_left,
                        plan[i].typed_right);
         end
         prev_kind = plan[i].kind;
      end

      // random phases: new lfo settings and a new idling pattern each time
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle_unit();
         write_reg(svd_pkg::CSR_LFO_SHAPE,
                   ($urandom & ~32'd1) | svd_pkg::CSR_DATA_W'(p % 2));
         case (p)
            1:       step_data = 32'd0;
            4:       step_data = 32'hFFFF_FFFF;
            3, 6:    step_data = $urandom_range(32'h0010_0000);
            default: step_data = $urandom;
         endcase
         write_reg(svd_pkg::CSR_LFO_PHASE_STEP, step_data);
         // mostly short rings so the blends read written samples
         case (p)
            0:       span_val = 13'd2;
            1:       span_val = 13'd4096;
            2:       span_val = 13'd1;
            3:       span_val = svd_pkg::SPAN_REG_W'($urandom_range(2, 16));
            4:       span_val = 13'd8191;
            5:       span_val = 13'd3;
            6:       span_val = svd_pkg::SPAN_REG_W'($urandom_range(2, 200));
            7:       span_val = svd_pkg::SPAN_REG_W'($urandom_range(2, 4096));
            default: span_val = svd_pkg::SPAN_REG_W'($urandom_range(4, 40));
         endcase
         write_reg(svd_pkg::CSR_DELAY_SPAN,
                   ($urandom & 32'hFFFF_E000) | svd_pkg::CSR_DATA_W'(span_val));
         if ($urandom_range(1) == 1) begin
            write_reg(CSR_SPARE_INDEX, $urandom);
         end
         csr_wr_en <= 1'b0;
         idle_mode <= idle_mode_type'(p % 4);
         // long response hold-off while requests keep coming, so input stalls
         if (p == 4) begin
            hold_req <= hold_req + 1;
         end
         repeat (FRAMES_PER_PHASE) begin
            fr.left  = pick_sample();
            fr.right = pick_sample();
            fr.last  = ($urandom_range(7) == 0);
            offer_frame(fr, 0, '0, '0);
         end
      end

      settle_unit();
      if (fail_count == 0) begin
         $display("[stereo_vibrato_delay_unit] OK");
      end else begin
         $display("[stereo_vibrato_delay_unit] ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin : watchdog
      #(2_000_000);
      $display("[stereo_vibrato_delay_unit] ERROR");
      $finish;
   end

endmodule

>>> filelist.f
hdl/svd_pkg.sv
hdl/svd_ram.sv
hdl/stereo_vibrato_delay_unit.sv
hdl/svd_check.sv
dv/stereo_vibrato_delay_unit_test.sv
